>>> hw/rtl/rib_pkg.sv
// ----------------------------------------------------------------------------
// rib_pkg
// Shared types and codes of the row interval builder.
// ----------------------------------------------------------------------------
package rib_pkg;

  localparam int unsigned DIAG_W  = 17;
  localparam int unsigned ROW_W   = 16;
  localparam int unsigned END_W   = 17;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned RIGHT_W = 18;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CNTO_W  = 5;
  localparam int unsigned CFGD_W  = 16;
  localparam int unsigned RUSE_W  = 13;

  localparam logic [END_W-1:0] ROW_LIMIT = 17'h10000;

  localparam logic [1:0] MODE_FWD   = 2'd0;
  localparam logic [1:0] MODE_BWD   = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_OUTSIDE  = 2'd2;

  localparam logic CFG_ROW_BASE    = 1'b0;
  localparam logic CFG_ROWS_IN_USE = 1'b1;

  typedef enum logic [1:0] {
    OP_INTEGRATE,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              backward;
    logic [DIAG_W-1:0] diag;
    logic [END_W-1:0]  first;
    logic [END_W-1:0]  last_end;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_ROW,
    S_ROW_CNT,
    S_ROW_UPD,
    S_RD_CHK,
    S_RD_SLOT,
    S_RD_DATA,
    S_CLEAR,
    S_DONE
  } state_t;

endpackage

>>> hw/rtl/rib_front.sv
// ----------------------------------------------------------------------------
// rib_front
// Accepts input beats, classifies them into commands and queues them.
// ----------------------------------------------------------------------------
module rib_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_mode,
  input  logic [rib_pkg::DIAG_W-1:0]    in_diag,
  input  logic [rib_pkg::ROW_W-1:0]     in_first_row,
  input  logic [rib_pkg::END_W-1:0]     in_end_row,
  input  logic [rib_pkg::SLOT_W-1:0]    in_slot,
  output logic                          cmd_valid,
  output rib_pkg::cmd_t                 cmd,
  input  logic                          cmd_pop
);

  rib_pkg::cmd_t queue_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  rib_pkg::cmd_t new_cmd;
  logic       push;
  logic       pop;

  always_comb begin
    new_cmd.backward = (in_mode == rib_pkg::MODE_BWD);
    new_cmd.diag     = in_diag;
    new_cmd.first    = {1'b0, in_first_row};
    new_cmd.last_end = (in_end_row > rib_pkg::ROW_LIMIT) ? rib_pkg::ROW_LIMIT : in_end_row;
    new_cmd.slot     = in_slot;
    case (in_mode)
      rib_pkg::MODE_FWD:   new_cmd.op = rib_pkg::OP_INTEGRATE;
      rib_pkg::MODE_BWD:   new_cmd.op = rib_pkg::OP_INTEGRATE;
      rib_pkg::MODE_READ:  new_cmd.op = rib_pkg::OP_READ;
      default:             new_cmd.op = rib_pkg::OP_CLEAR;
    endcase
  end

  assign in_stall  = (fill_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = queue_r[rd_ptr_r];
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

>>> hw/rtl/rib_back.sv
// ----------------------------------------------------------------------------
// rib_back
// Executes queued commands against the count and interval memories.
// ----------------------------------------------------------------------------
module rib_back #(
  parameter int unsigned ROW_DEPTH     = 4096,
  parameter int unsigned SLOTS_PER_ROW = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rib_pkg::CFGD_W-1:0]    cfg_wdata,
  input  logic                          cmd_valid,
  input  rib_pkg::cmd_t                 cmd,
  output logic                          cmd_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rib_pkg::STAT_W-1:0]    out_status,
  output logic [rib_pkg::CNTO_W-1:0]    out_row_intervals,
  output logic [rib_pkg::DIAG_W-1:0]    out_left_edge,
  output logic [rib_pkg::RIGHT_W-1:0]   out_right_edge,
  output logic                          out_slot_valid
);

  localparam int unsigned RW = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
  localparam int unsigned SW = (SLOTS_PER_ROW > 1) ? $clog2(SLOTS_PER_ROW) : 1;
  localparam int unsigned CW = $clog2(SLOTS_PER_ROW + 1);
  localparam int unsigned AW = RW + SW;
  localparam int unsigned EW = rib_pkg::END_W;
  localparam logic [EW-1:0] DEPTH_E = EW'(ROW_DEPTH);
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS_PER_ROW);

  logic [CW-1:0]                  cnt_mem   [2**RW];
  logic [rib_pkg::DIAG_W-1:0]     left_mem  [2**AW];
  logic [rib_pkg::RIGHT_W-1:0]    right_mem [2**AW];

  rib_pkg::state_t state_r, state_nxt;

  logic [rib_pkg::ROW_W-1:0]   row_base_r;
  logic [rib_pkg::RUSE_W-1:0]  rows_in_use_r;
  rib_pkg::cmd_t               cmd_r, cmd_nxt;
  logic [EW-1:0]               q_r, q_nxt;
  logic [EW-1:0]               limit_r, limit_nxt;
  logic                        outside_r, outside_nxt;
  logic                        over_r, over_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [rib_pkg::STAT_W-1:0]  res_status_r, res_status_nxt;
  logic [CW-1:0]               res_count_r, res_count_nxt;
  logic [rib_pkg::DIAG_W-1:0]  res_left_r, res_left_nxt;
  logic [rib_pkg::RIGHT_W-1:0] res_right_r, res_right_nxt;
  logic                        res_valid_r, res_valid_nxt;
  logic [rib_pkg::STAT_W-1:0]  out_status_r;
  logic [CW-1:0]               out_count_r;
  logic [rib_pkg::DIAG_W-1:0]  out_left_r;
  logic [rib_pkg::RIGHT_W-1:0] out_right_r;
  logic                        out_slot_valid_r;

  logic [CW-1:0]               cnt_q;
  logic [rib_pkg::DIAG_W-1:0]  left_q;
  logic [rib_pkg::RIGHT_W-1:0] right_q;

  logic                        cnt_we;
  logic [RW-1:0]               cnt_waddr;
  logic [CW-1:0]               cnt_wdata;
  logic                        left_we, right_we;
  logic [AW-1:0]               st_waddr;
  logic [AW-1:0]               st_raddr;
  logic [rib_pkg::DIAG_W-1:0]  left_wdata;
  logic [rib_pkg::RIGHT_W-1:0] right_wdata;

  logic [EW-1:0]               held;
  logic [EW-1:0]               diff;
  logic                        in_range;
  logic [RW-1:0]               rel;
  logic [rib_pkg::DIAG_W-1:0]  col;
  logic [rib_pkg::RIGHT_W-1:0] col_p1;
  logic [CW-1:0]               cnt_m1;
  logic [SW-1:0]               slot_idx;
  logic                        slot_hit;
  logic                        out_free;

  // held row window and row lookup
  always_comb begin
    held     = ({4'b0, rows_in_use_r} < DEPTH_E) ? {4'b0, rows_in_use_r} : DEPTH_E;
    diff     = q_r - {1'b0, row_base_r};
    in_range = (q_r >= {1'b0, row_base_r}) && (diff < held);
    rel      = diff[RW-1:0];
    col      = cmd_r.diag - q_r;
    col_p1   = {1'b0, col} + 18'd1;
    cnt_m1   = cnt_q - CW'(1);
    slot_idx = SW'({4'b0, cmd_r.slot});
    slot_hit = ({4'b0, cmd_r.slot} < 8'(cnt_q));
    out_free = !out_valid_r || !out_stall;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rib_pkg::S_INIT: begin
        if (q_r >= limit_r) state_nxt = rib_pkg::S_IDLE;
      end
      rib_pkg::S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            rib_pkg::OP_INTEGRATE: state_nxt = rib_pkg::S_ROW;
            rib_pkg::OP_READ:      state_nxt = rib_pkg::S_RD_CHK;
            default:               state_nxt = rib_pkg::S_CLEAR;
          endcase
        end
      end
      rib_pkg::S_ROW: begin
        if (q_r >= cmd_r.last_end) state_nxt = rib_pkg::S_DONE;
        else if (in_range) state_nxt = rib_pkg::S_ROW_CNT;
      end
      rib_pkg::S_ROW_CNT: state_nxt = rib_pkg::S_ROW_UPD;
      rib_pkg::S_ROW_UPD: state_nxt = rib_pkg::S_ROW;
      rib_pkg::S_RD_CHK:  state_nxt = in_range ? rib_pkg::S_RD_SLOT : rib_pkg::S_DONE;
      rib_pkg::S_RD_SLOT: state_nxt = slot_hit ? rib_pkg::S_RD_DATA : rib_pkg::S_DONE;
      rib_pkg::S_RD_DATA: state_nxt = rib_pkg::S_DONE;
      rib_pkg::S_CLEAR: begin
        if (q_r >= limit_r) state_nxt = rib_pkg::S_DONE;
      end
      rib_pkg::S_DONE: begin
        if (out_free) state_nxt = rib_pkg::S_IDLE;
      end
      default: state_nxt = rib_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cmd_nxt        = cmd_r;
    q_nxt          = q_r;
    limit_nxt      = limit_r;
    outside_nxt    = outside_r;
    over_nxt       = over_r;
    res_status_nxt = res_status_r;
    res_count_nxt  = res_count_r;
    res_left_nxt   = res_left_r;
    res_right_nxt  = res_right_r;
    res_valid_nxt  = res_valid_r;
    out_valid_nxt  = out_valid_r && out_stall;
    cmd_pop        = 1'b0;
    cnt_we         = 1'b0;
    cnt_waddr      = rel;
    cnt_wdata      = '0;
    left_we        = 1'b0;
    right_we       = 1'b0;
    st_waddr       = {rel, cnt_m1[SW-1:0]};
    st_raddr       = {rel, cnt_m1[SW-1:0]};
    left_wdata     = col;
    right_wdata    = col_p1;
    case (state_r)
      rib_pkg::S_INIT, rib_pkg::S_CLEAR: begin
        cnt_waddr = q_r[RW-1:0];
        if (q_r < limit_r) begin
          cnt_we = 1'b1;
          q_nxt  = q_r + EW'(1);
        end
      end
      rib_pkg::S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop        = 1'b1;
          cmd_nxt        = cmd;
          outside_nxt    = 1'b0;
          over_nxt       = 1'b0;
          res_status_nxt = rib_pkg::STATUS_OK;
          res_count_nxt  = '0;
          res_left_nxt   = '0;
          res_right_nxt  = '0;
          res_valid_nxt  = 1'b0;
          if (cmd.op == rib_pkg::OP_CLEAR) begin
            q_nxt     = '0;
            limit_nxt = held;
          end else begin
            q_nxt = cmd.first;
          end
        end
      end
      rib_pkg::S_ROW: begin
        if (q_r >= cmd_r.last_end) begin
          res_status_nxt = outside_r ? rib_pkg::STATUS_OUTSIDE :
                           over_r ? rib_pkg::STATUS_OVERFLOW : rib_pkg::STATUS_OK;
        end else if (!in_range) begin
          outside_nxt = 1'b1;
          q_nxt       = q_r + EW'(1);
        end
      end
      rib_pkg::S_ROW_UPD: begin
        q_nxt = q_r + EW'(1);
        if (cnt_q != '0 && !cmd_r.backward && {1'b0, col} <= right_q) begin
          right_we = 1'b1;
        end else if (cnt_q != '0 && cmd_r.backward && col_p1 >= {1'b0, left_q}) begin
          left_we = 1'b1;
        end else if (cnt_q >= SLOTS_C) begin
          // full row: widen the last interval
          over_nxt    = 1'b1;
          left_we     = 1'b1;
          right_we    = 1'b1;
          left_wdata  = (col < left_q) ? col : left_q;
          right_wdata = (col_p1 > right_q) ? col_p1 : right_q;
        end else begin
          left_we   = 1'b1;
          right_we  = 1'b1;
          st_waddr  = {rel, cnt_q[SW-1:0]};
          cnt_we    = 1'b1;
          cnt_wdata = cnt_q + CW'(1);
        end
      end
      rib_pkg::S_RD_CHK: begin
        if (!in_range) res_status_nxt = rib_pkg::STATUS_OUTSIDE;
      end
      rib_pkg::S_RD_SLOT: begin
        res_count_nxt = cnt_q;
        st_raddr      = {rel, slot_idx};
      end
      rib_pkg::S_RD_DATA: begin
        res_valid_nxt = 1'b1;
        res_left_nxt  = left_q;
        res_right_nxt = right_q;
      end
      rib_pkg::S_DONE: begin
        if (out_free) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= rib_pkg::S_INIT;
      q_r           <= '0;
      limit_r       <= DEPTH_E;
      out_valid_r   <= 1'b0;
      row_base_r    <= '0;
      rows_in_use_r <= 13'd1;
    end else begin
      state_r     <= state_nxt;
      q_r         <= q_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == rib_pkg::CFG_ROW_BASE) row_base_r <= cfg_wdata;
      if (cfg_we && cfg_index == rib_pkg::CFG_ROWS_IN_USE) begin
        rows_in_use_r <= cfg_wdata[rib_pkg::RUSE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    outside_r    <= outside_nxt;
    over_r       <= over_nxt;
    res_status_r <= res_status_nxt;
    res_count_r  <= res_count_nxt;
    res_left_r   <= res_left_nxt;
    res_right_r  <= res_right_nxt;
    res_valid_r  <= res_valid_nxt;
    if (state_r == rib_pkg::S_DONE && out_free) begin
      out_status_r     <= res_status_r;
      out_count_r      <= res_count_r;
      out_left_r       <= res_left_r;
      out_right_r      <= res_right_r;
      out_slot_valid_r <= res_valid_r;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_q <= cnt_mem[rel];
  end

  always_ff @(posedge clk) begin
    if (left_we) left_mem[st_waddr] <= left_wdata;
    left_q <= left_mem[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (right_we) right_mem[st_waddr] <= right_wdata;
    right_q <= right_mem[st_raddr];
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_row_intervals = rib_pkg::CNTO_W'({1'b0, out_count_r});
  assign out_left_edge     = out_left_r;
  assign out_right_edge    = out_right_r;
  assign out_slot_valid    = out_slot_valid_r;

endmodule

>>> hw/rtl/row_interval_builder.sv
// ----------------------------------------------------------------------------
// row_interval_builder
// Builds per-row column intervals from antidiagonal spans.
// ----------------------------------------------------------------------------
// An integrate beat walks its span one row at a time: a held row passes
// S_ROW, S_ROW_CNT and S_ROW_UPD, a row outside the held window S_ROW only,
// and each held row is a read-modify-write of the count and interval
// memories. A read beat steps through S_RD_CHK, S_RD_SLOT and S_RD_DATA as
// far as its row and slot are held; a clear beat walks the held rows. After
// reset a clearing pass zeroes all ROW_DEPTH counts before the first beat; up
// to two beats queue in front meanwhile; configuration writes are taken at any time.
module row_interval_builder #(
  parameter int unsigned ROW_DEPTH     = 4096,
  parameter int unsigned SLOTS_PER_ROW = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rib_pkg::CFGD_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_mode,
  input  logic [rib_pkg::DIAG_W-1:0]    in_diag,
  input  logic [rib_pkg::ROW_W-1:0]     in_first_row,
  input  logic [rib_pkg::END_W-1:0]     in_end_row,
  input  logic [rib_pkg::SLOT_W-1:0]    in_slot,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rib_pkg::STAT_W-1:0]    out_status,
  output logic [rib_pkg::CNTO_W-1:0]    out_row_intervals,
  output logic [rib_pkg::DIAG_W-1:0]    out_left_edge,
  output logic [rib_pkg::RIGHT_W-1:0]   out_right_edge,
  output logic                          out_slot_valid
);

  logic          cmd_valid;
  logic          cmd_pop;
  rib_pkg::cmd_t cmd;

  rib_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_diag      (in_diag),
    .in_first_row (in_first_row),
    .in_end_row   (in_end_row),
    .in_slot      (in_slot),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  rib_back #(
    .ROW_DEPTH     (ROW_DEPTH),
    .SLOTS_PER_ROW (SLOTS_PER_ROW)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_pop           (cmd_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_row_intervals (out_row_intervals),
    .out_left_edge     (out_left_edge),
    .out_right_edge    (out_right_edge),
    .out_slot_valid    (out_slot_valid)
  );

endmodule

>>> tb/rib_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rib_checker
// Watches the configuration port and both channels of the row interval
// builder, predicts each result from its own copy of the row state and
// compares every result beat field by field in order.
// ----------------------------------------------------------------------------
module rib_checker #(
  parameter int unsigned ROW_DEPTH     = 4096,
  parameter int unsigned SLOTS_PER_ROW = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [rib_pkg::CFGD_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [1:0]                   in_mode,
  input  logic [rib_pkg::DIAG_W-1:0]   in_diag,
  input  logic [rib_pkg::ROW_W-1:0]    in_first_row,
  input  logic [rib_pkg::END_W-1:0]    in_end_row,
  input  logic [rib_pkg::SLOT_W-1:0]   in_slot,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [rib_pkg::STAT_W-1:0]   out_status,
  input  logic [rib_pkg::CNTO_W-1:0]   out_row_intervals,
  input  logic [rib_pkg::DIAG_W-1:0]   out_left_edge,
  input  logic [rib_pkg::RIGHT_W-1:0]  out_right_edge,
  input  logic                         out_slot_valid,
  output int unsigned                  fail_count,
  output int unsigned                  pending
);

  typedef struct packed {
    logic [rib_pkg::STAT_W-1:0]  status;
    logic [rib_pkg::CNTO_W-1:0]  count;
    logic [rib_pkg::DIAG_W-1:0]  left;
    logic [rib_pkg::RIGHT_W-1:0] right;
    logic                        valid;
  } row_result_t;

  row_result_t                 expected_q[$];
  logic [rib_pkg::CNTO_W-1:0]  row_count[ROW_DEPTH];
  logic [rib_pkg::DIAG_W-1:0]  iv_left[ROW_DEPTH*SLOTS_PER_ROW];
  logic [rib_pkg::RIGHT_W-1:0] iv_right[ROW_DEPTH*SLOTS_PER_ROW];
  int unsigned                 base_row;
  int unsigned                 rows_used;

  function automatic int unsigned held_count();
    return (rows_used < ROW_DEPTH) ? rows_used : ROW_DEPTH;
  endfunction

  function automatic bit row_held(input int unsigned row, output int unsigned rel);
    rel = row - base_row;
    return (row >= base_row) && (row - base_row < held_count());
  endfunction

  // returns 1 when the cell had to be merged into a full row
  function automatic bit add_cell(input int unsigned rel, input int unsigned col,
                                  input bit backward);
    int unsigned cnt;
    int unsigned first_slot;
    int unsigned last;
    logic [rib_pkg::RIGHT_W-1:0] right;
    cnt        = row_count[rel];
    first_slot = rel * SLOTS_PER_ROW;
    right      = rib_pkg::RIGHT_W'(col + 1);
    if (cnt > 0) begin
      last = first_slot + cnt - 1;
      if (!backward && col <= iv_right[last]) begin
        iv_right[last] = right;
        return 0;
      end
      if (backward && col + 1 >= iv_left[last]) begin
        iv_left[last] = rib_pkg::DIAG_W'(col);
        return 0;
      end
    end
    if (cnt >= SLOTS_PER_ROW) begin
      last = first_slot + SLOTS_PER_ROW - 1;
      if (col < iv_left[last]) iv_left[last] = rib_pkg::DIAG_W'(col);
      if (right > iv_right[last]) iv_right[last] = right;
      return 1;
    end
    iv_left[first_slot + cnt]  = rib_pkg::DIAG_W'(col);
    iv_right[first_slot + cnt] = right;
    row_count[rel] = rib_pkg::CNTO_W'(cnt + 1);
    return 0;
  endfunction

  function automatic row_result_t predict_beat(input logic [1:0] mode,
                                               input int unsigned diag,
                                               input int unsigned first,
                                               input int unsigned end_row,
                                               input int unsigned slot);
    row_result_t res;
    int unsigned rel;
    int unsigned stop;
    int unsigned idx;
    bit outside;
    bit over;
    res     = '0;
    outside = 0;
    over    = 0;
    stop    = (end_row > 65536) ? 65536 : end_row;
    if (mode == rib_pkg::MODE_FWD || mode == rib_pkg::MODE_BWD) begin
      for (int unsigned q = first; q < stop; q++) begin
        if (!row_held(q, rel)) begin
          outside = 1;
        end else if (add_cell(rel, (diag - q) & 32'h1FFFF,
                              mode == rib_pkg::MODE_BWD)) begin
          over = 1;
        end
      end
      res.status = outside ? rib_pkg::STATUS_OUTSIDE :
                   (over ? rib_pkg::STATUS_OVERFLOW : rib_pkg::STATUS_OK);
    end else if (mode == rib_pkg::MODE_READ) begin
      if (!row_held(first, rel)) begin
        res.status = rib_pkg::STATUS_OUTSIDE;
      end else begin
        res.count = row_count[rel];
        if (slot < row_count[rel]) begin
          idx       = rel * SLOTS_PER_ROW + slot;
          res.valid = 1'b1;
          res.left  = iv_left[idx];
          res.right = iv_right[idx];
        end
      end
    end else begin
      for (int unsigned q = 0; q < held_count(); q++) row_count[q] = '0;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    row_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < ROW_DEPTH; i++) row_count[i] = '0;
      base_row   = 0;
      rows_used  = 1;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == rib_pkg::CFG_ROW_BASE) base_row = cfg_wdata;
        else                                    rows_used = cfg_wdata[rib_pkg::RUSE_W-1:0];
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_row_intervals !== want.count)
            report_mismatch("row_intervals", out_row_intervals, want.count);
          if (out_left_edge !== want.left)
            report_mismatch("left_edge", out_left_edge, want.left);
          if (out_right_edge !== want.right)
            report_mismatch("right_edge", out_right_edge, want.right);
          if (out_slot_valid !== want.valid)
            report_mismatch("slot_valid", out_slot_valid, want.valid);
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(predict_beat(in_mode, in_diag, in_first_row,
                                          in_end_row, in_slot));
    end
    pending = expected_q.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the row interval builder with directed and random span, read and
// clear beats under several row windows, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic                         cfg_index;
  logic [rib_pkg::CFGD_W-1:0]   cfg_wdata;
  logic                         in_valid;
  logic                         in_stall;
  logic [1:0]                   in_mode;
  logic [rib_pkg::DIAG_W-1:0]   in_diag;
  logic [rib_pkg::ROW_W-1:0]    in_first_row;
  logic [rib_pkg::END_W-1:0]    in_end_row;
  logic [rib_pkg::SLOT_W-1:0]   in_slot;
  logic                         out_valid;
  logic                         out_stall;
  logic [rib_pkg::STAT_W-1:0]   out_status;
  logic [rib_pkg::CNTO_W-1:0]   out_row_intervals;
  logic [rib_pkg::DIAG_W-1:0]   out_left_edge;
  logic [rib_pkg::RIGHT_W-1:0]  out_right_edge;
  logic                         out_slot_valid;
  int unsigned                  fail_count;
  int unsigned                  pending;

  bit                  quiet;
  bit                  hold_req;
  int unsigned         win_base;
  int unsigned         win_rows;
  int unsigned         last_diag;

  row_interval_builder uut (.*);

  rib_checker u_checker (.*);

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #24_000_000;
    $display("Verification failed");
    $finish;
  end

  // receiver side: short random stalls plus one long hold-off
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (399) @(posedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(0, 3)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= rib_pkg::CFGD_W'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_window(input int unsigned base, input int unsigned rows);
    write_reg(rib_pkg::CFG_ROW_BASE, base);
    @(posedge clk);
    write_reg(rib_pkg::CFG_ROWS_IN_USE, rows);
    @(posedge clk);
    win_base = base;
    win_rows = rows;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_beat(input logic [1:0] mode, input int unsigned diag,
                           input int unsigned first, input int unsigned end_row,
                           input int unsigned slot);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_diag      <= rib_pkg::DIAG_W'(diag);
    in_first_row <= rib_pkg::ROW_W'(first);
    in_end_row   <= rib_pkg::END_W'(end_row);
    in_slot      <= rib_pkg::SLOT_W'(slot);
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  task automatic random_beat();
    int unsigned pick;
    int unsigned first;
    int unsigned end_row;
    int unsigned diag;
    logic [1:0]  mode;
    pick = $urandom_range(0, 99);
    mode = (pick < 40) ? rib_pkg::MODE_FWD : (pick < 65) ? rib_pkg::MODE_BWD :
           (pick < 97) ? rib_pkg::MODE_READ : rib_pkg::MODE_CLEAR;
    if ($urandom_range(0, 9) == 0) first = $urandom_range(0, 65535);
    else first = (win_base + $urandom_range(0, win_rows + 2) - $urandom_range(0, 2))
                 & 32'hFFFF;
    // mostly short spans, now and then a long one or a full random end
    pick = $urandom_range(0, 299);
    if (pick == 0)      end_row = $urandom_range(0, 65536);
    else if (pick < 4)  end_row = first + $urandom_range(100, 600);
    else                end_row = first + $urandom_range(0, 12);
    if (end_row > 65536) end_row = 65536;
    pick = $urandom_range(0, 9);
    if (pick == 0)      diag = $urandom_range(0, 131071);
    else if (pick < 6)  diag = last_diag + $urandom_range(0, 4) - 2;
    else                diag = first + $urandom_range(0, 80);
    diag &= 32'h1FFFF;
    last_diag = diag;
    send_beat(mode, diag, first, end_row, $urandom_range(0, 15));
  endtask

  initial begin
    int unsigned bases[6];
    int unsigned sizes[6];
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_mode      = rib_pkg::MODE_FWD;
    in_diag      = '0;
    in_first_row = '0;
    in_end_row   = '0;
    in_slot      = '0;
    quiet        = 0;
    hold_req     = 0;
    last_diag    = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extend both ways, gaps, wrap, edges of the row space, overflow
    set_window(10, 20);
    send_beat(rib_pkg::MODE_FWD, 30, 10, 16, 0);
    send_beat(rib_pkg::MODE_FWD, 31, 10, 16, 0);
    send_beat(rib_pkg::MODE_BWD, 29, 10, 16, 0);
    send_beat(rib_pkg::MODE_BWD, 40, 10, 12, 0);
    send_beat(rib_pkg::MODE_READ, 0, 10, 0, 0);
    send_beat(rib_pkg::MODE_READ, 0, 10, 0, 1);
    send_beat(rib_pkg::MODE_READ, 0, 10, 0, 15);
    send_beat(rib_pkg::MODE_FWD, 50, 5, 12, 0);
    send_beat(rib_pkg::MODE_FWD, 50, 20, 20, 0);
    send_beat(rib_pkg::MODE_FWD, 50, 25, 3, 0);
    send_beat(rib_pkg::MODE_FWD, 0, 11, 14, 0);
    send_beat(rib_pkg::MODE_BWD, 131071, 12, 14, 0);
    send_beat(rib_pkg::MODE_FWD, 131071, 65535, 65536, 0);
    send_beat(rib_pkg::MODE_READ, 0, 65535, 0, 15);
    send_beat(rib_pkg::MODE_READ, 0, 9, 0, 0);
    for (int k = 0; k < 18; k++) send_beat(rib_pkg::MODE_FWD, 200 + 3 * k, 28, 30, 0);
    send_beat(rib_pkg::MODE_READ, 0, 28, 0, 15);
    send_beat(rib_pkg::MODE_CLEAR, 131071, 65535, 65536, 15);
    send_beat(rib_pkg::MODE_READ, 0, 10, 0, 0);
    drain();

    bases = '{0, 65535, 200, 64000, 3, 1000};
    sizes = '{4096, 1, 48, 4096, 1, 100};
    for (int ph = 0; ph < 6; ph++) begin
      set_window(bases[ph], sizes[ph]);
      if (ph == 2) hold_req = 1;
      for (int n = 0; n < 255; n++) begin
        if (ph == 5 && n == 60) quiet = 1;
        random_beat();
      end
      // sender waits for every result before the next window
      drain();
    end

    in_valid <= 1'b0;
    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/rib_pkg.sv
hw/rtl/rib_front.sv
hw/rtl/rib_back.sv
hw/rtl/row_interval_builder.sv
tb/rib_checker.sv
tb/tb_top.sv
